// ===== rtl/core/lned_pkg.sv =====
// Shared types and constants of the console line editor.
// No dependencies; the cell, sequencer, top level, checker and testbench import this package.
package lned_pkg;

   // Line store geometry: the line holds at most LINE_LEN-1 characters
   localparam int LINE_LEN = 16;
   localparam int IW       = $clog2(LINE_LEN);

   // Character codes
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_ESC     = 8'h1b;
   localparam logic [7:0] CH_SP      = 8'h20;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_LBRACK  = 8'h5b;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_DEL     = 8'h7f;
   localparam logic [7:0] EXT_LEFT   = 8'd228;
   localparam logic [7:0] EXT_RIGHT  = 8'd229;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,
      KIND_LINE    = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ABANDON = 2'd3
   } kind_type;

   // Escape sequence tracking; the fourth code behaves as idle
   typedef enum logic [1:0] {
      ESC_IDLE    = 2'd0,
      ESC_SEEN    = 2'd1,
      ESC_BRACKET = 2'd2
   } esc_type;

   // Command broadcast to every storage cell
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_INS  = 2'd1,
      CELL_DEL  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type   op;
      logic [IW-1:0] cur;
      logic [IW-1:0] len;
      logic [7:0]    data;
   } cell_ctl_type;

endpackage

// ===== rtl/core/lned_ifs.sv =====
// Channel interfaces of the console line editor: request, response, csr write.
// Depends on nothing; payload widths are fixed by the beat format.
interface lned_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_code;

   modport source (output valid, output action, output char_code, input ready);
   modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface lned_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_value;
   logic       last;

   modport source (output valid, output kind, output char_value, output last, input ready);
   modport sink   (input valid, input kind, input char_value, input last, output ready);
endinterface

interface lned_csr_if;
   logic valid;
   logic ready;
   logic echo_enable;

   modport source (output valid, output echo_enable, input ready);
   modport sink   (input valid, input echo_enable, output ready);
endinterface

// ===== rtl/core/lned_cell.sv =====
// One character cell of the line store chain.
// Depends on lned_pkg; takes from its left or right neighbor on insert or delete.
module lned_cell (
   input  logic                  clock,
   input  lned_pkg::cell_ctl_type ctl,
   input  logic [lned_pkg::IW-1:0] pos,
   input  logic [7:0]            left_q,
   input  logic [7:0]            right_q,
   output logic [7:0]            q
);
   import lned_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic [IW:0] pos_nx;

   assign pos_nx = {1'b0, pos} + (IW+1)'(1);

   // Select the next content of this cell
   always_comb begin
      data_in = data_ff;
      unique case (ctl.op)
         CELL_HOLD: data_in = data_ff;
         CELL_INS: begin
            if (pos == ctl.cur) begin
               data_in = ctl.data;
            end else if (pos > ctl.cur && pos <= ctl.len) begin
               data_in = left_q;
            end
         end
         CELL_DEL: begin
            if (pos_nx == {1'b0, ctl.len}) begin
               data_in = CH_SP;
            end else if (pos_nx >= {1'b0, ctl.cur} && pos_nx < {1'b0, ctl.len}) begin
               data_in = right_q;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;
endmodule

// ===== rtl/core/lned_seq.sv =====
// Edit sequencer: decodes each request beat, drives the cell chain and emits
// response beats, at most one per step. Depends on lned_pkg and lned_ifs.
module lned_seq (
   input  logic                    clock,
   input  logic                    reset,
   lned_req_if.sink                req,
   lned_rsp_if.source              rsp,
   lned_csr_if.sink                csr,
   output lned_pkg::cell_ctl_type  cell_ctl,
   output logic [lned_pkg::IW-1:0] rd_addr,
   input  logic [7:0]              rd_data
);
   import lned_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_INS      = 12'b0000_0000_0010,
      ST_DEL      = 12'b0000_0000_0100,
      ST_DEL_END  = 12'b0000_0000_1000,
      ST_TAIL     = 12'b0000_0001_0000,
      ST_BACK     = 12'b0000_0010_0000,
      ST_STEP_R   = 12'b0000_0100_0000,
      ST_MOVE_L   = 12'b0000_1000_0000,
      ST_FIN_LF   = 12'b0001_0000_0000,
      ST_FIN_LINE = 12'b0010_0000_0000,
      ST_ABANDON  = 12'b0100_0000_0000,
      ST_FLUSH    = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      OP_INS = 2'd0,
      OP_DEL = 2'd1,
      OP_FIN = 2'd2,
      OP_MOV = 2'd3
   } op_type;

   localparam logic [IW-1:0] FULL_LEN = IW'(LINE_LEN - 1);

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   esc_type       esc_ff, esc_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [7:0]    ins_ff, ins_in;
   logic [7:0]    sec_ff, sec_in;
   logic          two_ff, two_in;
   logic          echo_ff, echo_in;
   logic          hb_valid_ff, hb_valid_in;
   kind_type      hb_kind_ff, hb_kind_in;
   logic [7:0]    hb_char_ff, hb_char_in;
   logic          out_valid_ff, out_valid_in;
   kind_type      out_kind_ff, out_kind_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_last_ff, out_last_in;

   logic          accept;
   logic          go;
   logic          out_free;
   logic          emit;
   kind_type      em_kind;
   logic [7:0]    em_char;
   logic          gen;
   logic          flush_load;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp.ready;
   // A step may run when the held-back beat can move on
   assign go        = !hb_valid_ff || out_free;
   assign rd_addr   = (state_ff == ST_STEP_R) ? cur_ff : idx_ff;

   // Sequencer next state and cell commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      esc_in     = esc_ff;
      cur_in     = cur_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      ins_in     = ins_ff;
      sec_in     = sec_ff;
      two_in     = two_ff;
      emit       = 1'b0;
      em_kind    = KIND_ECHO;
      em_char    = 8'd0;
      flush_load = 1'b0;
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.cur  = cur_ff;
      cell_ctl.len  = len_ff;
      cell_ctl.data = ins_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               two_in = 1'b0;
               if (req.action) begin
                  // End of stream: drop the line
                  cur_in   = '0;
                  len_in   = '0;
                  esc_in   = ESC_IDLE;
                  state_in = ST_ABANDON;
               end else if (esc_ff == ESC_SEEN) begin
                  if (req.char_code == CH_LBRACK) begin
                     esc_in = ESC_BRACKET;
                  end else begin
                     esc_in   = ESC_IDLE;
                     ins_in   = req.char_code;
                     op_in    = OP_INS;
                     state_in = ST_INS;
                  end
               end else if (esc_ff == ESC_BRACKET) begin
                  esc_in = ESC_IDLE;
                  priority if (req.char_code == CH_D) begin
                     op_in    = OP_MOV;
                     state_in = ST_MOVE_L;
                  end else if (req.char_code == CH_C) begin
                     op_in    = OP_MOV;
                     state_in = ST_STEP_R;
                  end else begin
                     ins_in   = CH_LBRACK;
                     sec_in   = req.char_code;
                     two_in   = 1'b1;
                     op_in    = OP_INS;
                     state_in = ST_INS;
                  end
               end else begin
                  esc_in = ESC_IDLE;
                  priority if (req.char_code == CH_BS || req.char_code == CH_DEL) begin
                     if (cur_ff != '0) begin
                        op_in    = OP_DEL;
                        state_in = ST_DEL;
                     end
                  end else if (req.char_code >= CH_SP && req.char_code <= CH_TILDE) begin
                     ins_in   = req.char_code;
                     op_in    = OP_INS;
                     state_in = ST_INS;
                  end else if (req.char_code == CH_LF || req.char_code == CH_CR) begin
                     op_in = OP_FIN;
                     if (echo_ff) begin
                        idx_in   = cur_ff;
                        state_in = ST_TAIL;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_FIN_LINE;
                     end
                  end else if (req.char_code == CH_ESC) begin
                     esc_in = ESC_SEEN;
                  end else if (req.char_code > CH_DEL) begin
                     priority if (req.char_code == EXT_LEFT) begin
                        op_in    = OP_MOV;
                        state_in = ST_MOVE_L;
                     end else if (req.char_code == EXT_RIGHT) begin
                        op_in    = OP_MOV;
                        state_in = ST_STEP_R;
                     end else begin
                        ins_in   = req.char_code;
                        op_in    = OP_INS;
                        state_in = ST_INS;
                     end
                  end
               end
            end
         end

         ST_INS: begin
            if (go) begin
               if (len_ff == FULL_LEN) begin
                  // Store full: drop this insert
                  if (two_ff) begin
                     two_in = 1'b0;
                     ins_in = sec_ff;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else if (cur_ff == len_ff) begin
                  cell_ctl.op = CELL_INS;
                  cur_in  = cur_ff + IW'(1);
                  len_in  = len_ff + IW'(1);
                  emit    = 1'b1;
                  em_char = ins_ff;
                  if (two_ff) begin
                     two_in = 1'b0;
                     ins_in = sec_ff;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  cell_ctl.op = CELL_INS;
                  len_in   = len_ff + IW'(1);
                  idx_in   = cur_ff;
                  state_in = ST_TAIL;
               end
            end
         end

         ST_DEL: begin
            if (go) begin
               if (cur_ff == len_ff) begin
                  cur_in   = cur_ff - IW'(1);
                  len_in   = len_ff - IW'(1);
                  cnt_in   = 2'd0;
                  state_in = ST_DEL_END;
               end else begin
                  cell_ctl.op = CELL_DEL;
                  emit     = 1'b1;
                  em_char  = CH_BS;
                  cur_in   = cur_ff - IW'(1);
                  idx_in   = cur_ff - IW'(1);
                  state_in = ST_TAIL;
               end
            end
         end

         ST_DEL_END: begin
            // Erase the last character on screen: BS, space, BS
            if (go) begin
               emit    = 1'b1;
               em_char = (cnt_ff == 2'd1) ? CH_SP : CH_BS;
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd2) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_TAIL: begin
            if (go) begin
               if (idx_ff < len_ff) begin
                  emit    = 1'b1;
                  em_char = rd_data;
                  idx_in  = idx_ff + IW'(1);
               end else if (op_ff == OP_FIN) begin
                  state_in = ST_FIN_LF;
               end else begin
                  idx_in   = cur_ff;
                  state_in = ST_BACK;
               end
            end
         end

         ST_BACK: begin
            if (go) begin
               if (idx_ff < len_ff) begin
                  emit    = 1'b1;
                  em_char = CH_BS;
                  idx_in  = idx_ff + IW'(1);
               end else if (op_ff == OP_INS) begin
                  state_in = ST_STEP_R;
               end else begin
                  len_in   = len_ff - IW'(1);
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_STEP_R: begin
            if (go) begin
               if (cur_ff < len_ff) begin
                  emit    = 1'b1;
                  em_char = rd_data;
                  cur_in  = cur_ff + IW'(1);
               end
               if (op_ff == OP_INS && two_ff) begin
                  two_in   = 1'b0;
                  ins_in   = sec_ff;
                  state_in = ST_INS;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_MOVE_L: begin
            if (go) begin
               if (cur_ff != '0) begin
                  emit    = 1'b1;
                  em_char = CH_BS;
                  cur_in  = cur_ff - IW'(1);
               end
               state_in = ST_FLUSH;
            end
         end

         ST_FIN_LF: begin
            if (go) begin
               emit     = 1'b1;
               em_char  = CH_LF;
               idx_in   = '0;
               state_in = ST_FIN_LINE;
            end
         end

         ST_FIN_LINE: begin
            if (go) begin
               emit = 1'b1;
               if (idx_ff < len_ff) begin
                  em_kind = KIND_LINE;
                  em_char = rd_data;
                  idx_in  = idx_ff + IW'(1);
               end else begin
                  em_kind  = KIND_DONE;
                  cur_in   = '0;
                  len_in   = '0;
                  esc_in   = ESC_IDLE;
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_ABANDON: begin
            if (go) begin
               emit     = 1'b1;
               em_kind  = KIND_ABANDON;
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            // Release the held-back beat as the final one of this item
            if (!hb_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               flush_load = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Suppress echo beats when echo is off
   assign gen = emit && (em_kind != KIND_ECHO || echo_ff);

   // Hold back one beat so the final beat of an item can be marked
   always_comb begin
      hb_valid_in  = hb_valid_ff;
      hb_kind_in   = hb_kind_ff;
      hb_char_in   = hb_char_ff;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (go && gen) begin
         if (hb_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = hb_kind_ff;
            out_char_in  = hb_char_ff;
            out_last_in  = 1'b0;
         end
         hb_valid_in = 1'b1;
         hb_kind_in  = em_kind;
         hb_char_in  = em_char;
      end else if (flush_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = hb_kind_ff;
         out_char_in  = hb_char_ff;
         out_last_in  = 1'b1;
         hb_valid_in  = 1'b0;
      end
   end

   // Echo enable register
   always_comb begin
      echo_in = echo_ff;
      if (csr.valid && csr.ready) begin
         echo_in = csr.echo_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         esc_ff       <= ESC_IDLE;
         cur_ff       <= '0;
         len_ff       <= '0;
         two_ff       <= 1'b0;
         echo_ff      <= 1'b1;
         hb_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esc_ff       <= esc_in;
         cur_ff       <= cur_in;
         len_ff       <= len_in;
         two_ff       <= two_in;
         echo_ff      <= echo_in;
         hb_valid_ff  <= hb_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      ins_ff      <= ins_in;
      sec_ff      <= sec_in;
      hb_kind_ff  <= hb_kind_in;
      hb_char_ff  <= hb_char_in;
      out_kind_ff <= out_kind_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.kind       = out_kind_ff;
   assign rsp.char_value = out_char_ff;
   assign rsp.last       = out_last_ff;
endmodule

// ===== rtl/core/line_editor_with_cursor.sv =====
// Top level of the console line editor: cell chain plus edit sequencer.
// Depends on lned_pkg, lned_ifs, lned_cell and lned_seq.
//
// Console line editor with an insertion cursor. Each request beat carries one
// received character or an end-of-stream mark; each response beat carries one
// echo character, one character of a finished line, a line-finished tag or a
// line-abandoned tag, with last set on the final beat of a request. The line is
// held in a chain of LINE_LEN character cells that shift as one on an insert
// or a delete. One request is handled at a time: the sequencer emits at most one
// response beat per step, stalled by back-pressure on the response channel, and
// releases the final beat in a closing flush step. The longest requests come
// when ESC [ is followed by a byte that inserts '[' and that byte at the start of
// a line of LINE_LEN-3 characters (two full tail redraws). The user must write the
// echo enable register through the csr channel only while no request is in
// progress; the block itself does not enforce this.
module line_editor_with_cursor (
   input  logic         clock,
   input  logic         reset,
   lned_req_if.sink     req_port,
   lned_rsp_if.source   rsp_port,
   lned_csr_if.sink     csr_port
);
   import lned_pkg::*;

   cell_ctl_type  cell_ctl;
   logic [IW-1:0] rd_addr;
   logic [7:0]    cell_q [LINE_LEN];

   // Edit sequencer
   lned_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req      (req_port),
      .rsp      (rsp_port),
      .csr      (csr_port),
      .cell_ctl (cell_ctl),
      .rd_addr  (rd_addr),
      .rd_data  (cell_q[rd_addr])
   );

   // Chain of character cells, each linked to its neighbors; the end cells see constants
   for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
      logic [7:0] left_q;
      logic [7:0] right_q;

      if (i == 0) begin : g_first
         assign left_q = 8'd0;
      end else begin : g_mid_l
         assign left_q = cell_q[i-1];
      end

      if (i == LINE_LEN - 1) begin : g_last
         assign right_q = CH_SP;
      end else begin : g_mid_r
         assign right_q = cell_q[i+1];
      end

      lned_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl),
         .pos     (IW'(i)),
         .left_q  (left_q),
         .right_q (right_q),
         .q       (cell_q[i])
      );
   end
endmodule

// ===== rtl/core/lned_check.sv =====
// Port-level checker of the console line editor and its bind to the top level.
// Depends on lned_pkg and line_editor_with_cursor.
module lned_check (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_char_value,
   input logic       rsp_last
);
   import lned_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_char_value) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // Reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Tag beats carry no character
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ABANDON)
         |-> rsp_char_value == 8'd0)
      else $error("tag beat with nonzero character");

   // Tag beats close their request
   a_tag_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ABANDON) |-> rsp_last)
      else $error("tag beat not marked last");
endmodule

bind line_editor_with_cursor lned_check u_lned_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_kind       (rsp_port.kind),
   .rsp_char_value (rsp_port.char_value),
   .rsp_last       (rsp_port.last)
);

// ===== test/tb.sv =====
// Self-checking testbench for the console line editor with cursor.
// Depends on lned_pkg, the lned_*_if channel interfaces and line_editor_with_cursor.
`timescale 1ns / 100ps

module tb;
   import lned_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned SETTLE_CYCLES = 48;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned GAP_PERCENT   = 11;

   // One expected response beat
   typedef struct {
      kind_type   kind;
      logic [7:0] char_value;
      logic       last;
   } line_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lned_req_if req_ch ();
   lned_rsp_if rsp_ch ();
   lned_csr_if csr_ch ();

   line_editor_with_cursor dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // Shadow copy of the editor state
   logic [7:0]  shadow_line [LINE_LEN];
   int          shadow_cursor = 0;
   int          shadow_length = 0;
   esc_type     shadow_esc    = ESC_IDLE;
   logic        shadow_echo   = 1'b1;

   line_beat_type  step_beats [$];
   line_beat_type  pending_output [$];

   int unsigned failures    = 0;
   int unsigned cycle_count = 0;
   int unsigned keys_sent   = 0;
   bit          gaps_on     = 1'b1;
   bit          hold_armed  = 1'b0;
   logic        rsp_hold    = 1'b0;

   always #5 clock = ~clock;

   // Line state prediction

   function automatic void emit_beat(kind_type k, logic [7:0] v);
      step_beats.push_back('{k, v, 1'b0});
   endfunction

   function automatic void echo_char(logic [7:0] v);
      if (shadow_echo) emit_beat(KIND_ECHO, v);
   endfunction

   function automatic void clear_shadow();
      shadow_cursor = 0;
      shadow_length = 0;
      shadow_esc    = ESC_IDLE;
   endfunction

   // Repaint from the cursor to the end, then walk back
   function automatic void redraw_tail();
      for (int i = shadow_cursor; i < shadow_length; i++) echo_char(shadow_line[i]);
      for (int i = shadow_cursor; i < shadow_length; i++) echo_char(CH_BS);
   endfunction

   function automatic void cursor_left();
      if (shadow_cursor > 0) begin
         echo_char(CH_BS);
         shadow_cursor--;
      end
   endfunction

   function automatic void cursor_right();
      if (shadow_cursor < shadow_length) begin
         echo_char(shadow_line[shadow_cursor]);
         shadow_cursor++;
      end
   endfunction

   function automatic void shadow_insert(logic [7:0] c);
      if (shadow_length >= LINE_LEN - 1) return;
      if (shadow_cursor == shadow_length) begin
         shadow_line[shadow_cursor] = c;
         shadow_cursor++;
         shadow_length++;
         echo_char(c);
      end else begin
         for (int i = shadow_length; i > shadow_cursor; i--) shadow_line[i] = shadow_line[i-1];
         shadow_line[shadow_cursor] = c;
         shadow_length++;
         redraw_tail();
         cursor_right();
      end
   endfunction

   function automatic void delete_char();
      if (shadow_cursor == shadow_length) begin
         shadow_cursor--;
         shadow_length--;
         echo_char(CH_BS);
         echo_char(CH_SP);
         echo_char(CH_BS);
      end else begin
         for (int i = shadow_cursor - 1; i < shadow_length - 1; i++)
            shadow_line[i] = shadow_line[i+1];
         shadow_line[shadow_length-1] = CH_SP;
         cursor_left();
         redraw_tail();
         shadow_length--;
      end
   endfunction

   function automatic void finish_line();
      if (shadow_echo) begin
         for (int i = shadow_cursor; i < shadow_length; i++) echo_char(shadow_line[i]);
         echo_char(CH_LF);
      end
      for (int i = 0; i < shadow_length; i++) emit_beat(KIND_LINE, shadow_line[i]);
      emit_beat(KIND_DONE, 8'h00);
      clear_shadow();
   endfunction

   // Work out every response beat of one accepted keystroke
   function automatic void apply_keystroke(logic act, logic [7:0] c);
      line_beat_type tail_beat;
      step_beats.delete();
      if (act) begin
         emit_beat(KIND_ABANDON, 8'h00);
         clear_shadow();
      end else if (shadow_esc == ESC_SEEN) begin
         if (c == CH_LBRACK) begin
            shadow_esc = ESC_BRACKET;
         end else begin
            shadow_esc = ESC_IDLE;
            shadow_insert(c);
         end
      end else if (shadow_esc == ESC_BRACKET) begin
         shadow_esc = ESC_IDLE;
         if (c == CH_D) cursor_left();
         else if (c == CH_C) cursor_right();
         else begin
            shadow_insert(CH_LBRACK);
            shadow_insert(c);
         end
      end else begin
         shadow_esc = ESC_IDLE;
         if (c == CH_BS || c == CH_DEL) begin
            if (shadow_cursor > 0) delete_char();
         end else if (c >= CH_SP && c <= CH_TILDE) begin
            shadow_insert(c);
         end else if (c == CH_LF || c == CH_CR) begin
            finish_line();
         end else if (c == CH_ESC) begin
            shadow_esc = ESC_SEEN;
         end else if (c > CH_DEL) begin
            if (c == EXT_LEFT) cursor_left();
            else if (c == EXT_RIGHT) cursor_right();
            else shadow_insert(c);
         end
      end
      // Flag the final beat of this keystroke
      if (step_beats.size() > 0) begin
         tail_beat = step_beats.pop_back();
         tail_beat.last = 1'b1;
         step_beats.push_back(tail_beat);
      end
      foreach (step_beats[i]) pending_output.push_back(step_beats[i]);
   endfunction

   // Response side: check each beat, drive ready with random gaps

   task automatic check_beat(logic [1:0] k, logic [7:0] v, logic l);
      line_beat_type want;
      if (pending_output.size() == 0) begin
         $error("unexpected response beat: kind %0d char_value %02h last %0b", k, v, l);
         failures++;
         return;
      end
      want = pending_output.pop_front();
      if (k !== want.kind) begin
         $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
         failures++;
      end
      if (v !== want.char_value) begin
         $error("char_value mismatch: expected %02h, actual %02h", want.char_value, v);
         failures++;
      end
      if (l !== want.last) begin
         $error("last mismatch: expected %0b, actual %0b", want.last, l);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         check_beat(rsp_ch.kind, rsp_ch.char_value, rsp_ch.last);
      rsp_ch.ready <= !rsp_hold && !(gaps_on && $urandom_range(99) < GAP_PERCENT);
   end

   // Long receiver hold-off, started once by the stall test
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Request side

   // Offer one beat, hold until taken, then maybe idle a little
   task automatic send_key(logic act, logic [7:0] c);
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.char_code <= c;
      do @(posedge clock); while (!req_ch.ready);
      apply_keystroke(act, c);
      keys_sent++;
      if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every expected beat, then let the block go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_output.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_echo(logic enable);
      csr_ch.valid       <= 1'b1;
      csr_ch.echo_enable <= enable;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      shadow_echo = enable;
   endtask

   task automatic type_burst(int unsigned count);
      repeat (count) send_key(1'b0, 8'($urandom_range(CH_SP, CH_TILDE)));
   endtask

   task automatic move_cursor(int unsigned sel);
      case (sel)
         0: begin
            send_key(1'b0, CH_ESC);
            send_key(1'b0, CH_LBRACK);
            send_key(1'b0, CH_D);
         end
         1: begin
            send_key(1'b0, CH_ESC);
            send_key(1'b0, CH_LBRACK);
            send_key(1'b0, CH_C);
         end
         2: send_key(1'b0, EXT_LEFT);
         default: send_key(1'b0, EXT_RIGHT);
      endcase
   endtask

   // Tests

   // Printable extremes, arrow keys, insert in the middle, move past the end
   task automatic test_insert_and_move();
      send_key(1'b0, CH_SP);
      send_key(1'b0, CH_TILDE);
      send_key(1'b0, "a");
      move_cursor(0);
      send_key(1'b0, "b");
      send_key(1'b0, EXT_LEFT);
      repeat (3) send_key(1'b0, EXT_RIGHT);
   endtask

   // Delete inside and at the end, ignored controls, delete at line start
   task automatic test_delete_and_controls();
      send_key(1'b0, EXT_LEFT);
      send_key(1'b0, CH_DEL);
      send_key(1'b0, CH_BS);
      send_key(1'b0, 8'h01);
      send_key(1'b0, 8'h00);
      repeat (2) send_key(1'b0, EXT_RIGHT);
      send_key(1'b0, CH_BS);
      send_key(1'b0, CH_CR);
      send_key(1'b0, CH_BS);
   endtask

   // Stray bytes after ESC and after ESC [, extended codes, LF finish
   task automatic test_escape_sequences();
      send_key(1'b0, CH_ESC);
      send_key(1'b0, 8'h00);
      send_key(1'b0, CH_ESC);
      send_key(1'b0, CH_LBRACK);
      send_key(1'b0, 8'hff);
      send_key(1'b0, 8'h80);
      send_key(1'b0, EXT_LEFT);
      move_cursor(1);
      send_key(1'b0, CH_ESC);
      send_key(1'b0, CH_ESC);
      send_key(1'b0, CH_LF);
   endtask

   // Abandon mid-line, inside an escape sequence and on an empty line
   task automatic test_end_of_stream();
      send_key(1'b0, "q");
      send_key(1'b0, CH_ESC);
      send_key(1'b1, 8'hff);
      send_key(1'b0, CH_ESC);
      send_key(1'b0, CH_LBRACK);
      send_key(1'b1, 8'h00);
      send_key(1'b1, 8'h5a);
   endtask

   // Hold the receiver off while the sender keeps offering beats
   task automatic test_receiver_stall();
      hold_armed = 1'b1;
      type_burst(8);
      move_cursor(2);
      move_cursor(2);
      type_burst(4);
      send_key(1'b0, CH_LF);
      type_burst(6);
      send_key(1'b0, CH_CR);
   endtask

   // Mostly well-formed editing with random content, plus noise
   task automatic test_random_edits(int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = keys_sent + count;
      while (keys_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 5) type_burst($urandom_range(12, 18));
         else if (pick < 40) type_burst($urandom_range(1, 6));
         else if (pick < 55) repeat ($urandom_range(1, 4)) move_cursor($urandom_range(3));
         else if (pick < 67)
            repeat ($urandom_range(1, 3)) send_key(1'b0, $urandom_range(1) ? CH_BS : CH_DEL);
         else if (pick < 75) send_key(1'b0, $urandom_range(1) ? CH_CR : CH_LF);
         else if (pick < 78) send_key(1'b1, 8'($urandom));
         else if (pick < 82) begin
            send_key(1'b0, CH_ESC);
            send_key(1'b0, 8'($urandom));
         end else if (pick < 86) begin
            send_key(1'b0, CH_ESC);
            send_key(1'b0, CH_LBRACK);
            send_key(1'b0, 8'($urandom));
         end else begin
            send_key(1'b0, 8'($urandom));
         end
      end
   endtask

   // Sequence of tests
   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.action      <= 1'b0;
      req_ch.char_code   <= 8'h00;
      csr_ch.valid       <= 1'b0;
      csr_ch.echo_enable <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_insert_and_move();
      test_delete_and_controls();
      test_escape_sequences();
      test_end_of_stream();
      settle();

      write_echo(1'b1);
      test_receiver_stall();
      test_random_edits(90);
      settle();

      write_echo(1'b0);
      test_random_edits(100);
      settle();

      // Stretch with no idling on either side
      write_echo(1'b1);
      gaps_on = 1'b0;
      test_random_edits(110);
      settle();
      gaps_on = 1'b1;

      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/lned_pkg.sv
rtl/core/lned_ifs.sv
rtl/core/lned_cell.sv
rtl/core/lned_seq.sv
rtl/core/line_editor_with_cursor.sv
rtl/core/lned_check.sv
test/tb.sv
